// ===== design/spq_pkg.sv =====
// shared constants and types for the stable sorted priority queue
package spq_pkg;

  // default sizes
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned KeyBitsDef    = 32;
  localparam int unsigned TagBitsDef    = 16;

  // operation codes on kind_i
  localparam logic KindInsert = 1'b0;
  localparam logic KindPop    = 1'b1;

  // result codes on outcome_o
  localparam logic [1:0] OutInserted = 2'd0;
  localparam logic [1:0] OutPopped   = 2'd1;
  localparam logic [1:0] OutEmpty    = 2'd2;
  localparam logic [1:0] OutFull     = 2'd3;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

endpackage

// ===== design/spq_cell.sv =====
// one slot of the sorted shift chain: holds a key and a tag
module spq_cell #(
  parameter int unsigned KEY_BITS = spq_pkg::KeyBitsDef,
  parameter int unsigned TAG_BITS = spq_pkg::TagBitsDef
) (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                valid_i,
  input  logic [KEY_BITS-1:0] new_key_i,
  input  logic [TAG_BITS-1:0] new_tag_i,
  input  logic                left_gt_i,
  input  logic [KEY_BITS-1:0] left_key_i,
  input  logic [TAG_BITS-1:0] left_tag_i,
  input  logic [KEY_BITS-1:0] right_key_i,
  input  logic [TAG_BITS-1:0] right_tag_i,
  output logic                gt_o,
  output logic [KEY_BITS-1:0] key_o,
  output logic [TAG_BITS-1:0] tag_o
);

  logic [KEY_BITS-1:0] key_d, key_q;
  logic [TAG_BITS-1:0] tag_d, tag_q;

  // slot lies behind the insert point: empty, or strictly larger key
  assign gt_o = !valid_i || (key_q > new_key_i);

  // next content: keep, take new entry, shift from left or from right
  always_comb begin
    key_d = key_q;
    tag_d = tag_q;
    if (ctrl_i.ins) begin
      if (gt_o && !left_gt_i) begin
        key_d = new_key_i;
        tag_d = new_tag_i;
      end else if (gt_o) begin
        key_d = left_key_i;
        tag_d = left_tag_i;
      end
    end else if (ctrl_i.pop) begin
      key_d = right_key_i;
      tag_d = right_tag_i;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign key_o = key_q;
  assign tag_o = tag_q;

endmodule

// ===== design/stable_sorted_priority_queue.sv =====
// Sorted priority queue built as a chain of compare-and-shift cells. One command
// (insert or pop) is taken per clock cycle; busy_o stays low, and every
// command yields exactly one result in the cycle after its transfer, marked by
// done_o for a single cycle. All cells compare the new key against their own
// in parallel and shift in the same cycle, so the rate is one command per cycle
// at any depth; the key comparator in each cell sets the cycle time. Equal keys
// leave in arrival order. The receiver cannot hold results off.
module stable_sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QueueDepthDef,
  parameter int unsigned KEY_BITS    = spq_pkg::KeyBitsDef,
  parameter int unsigned TAG_BITS    = spq_pkg::TagBitsDef,
  localparam int unsigned CntW       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                kind_i,
  input  logic [KEY_BITS-1:0] due_key_i,
  input  logic [TAG_BITS-1:0] task_tag_i,
  output logic                done_o,
  output logic [1:0]          outcome_o,
  output logic [TAG_BITS-1:0] popped_tag_o,
  output logic [KEY_BITS-1:0] popped_key_o,
  output logic [CntW-1:0]     occupancy_o
);

  localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);

  logic [CntW-1:0]     count_d, count_q;
  logic                done_q;
  logic [1:0]          outcome_d, outcome_q;
  logic [TAG_BITS-1:0] ptag_d, ptag_q;
  logic [KEY_BITS-1:0] pkey_d, pkey_q;

  logic                accept, full, empty;
  spq_pkg::cell_ctrl_t ctrl;

  logic [QUEUE_DEPTH-1:0] valid_v, gt_v;
  logic [KEY_BITS-1:0]    key_v [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]    tag_v [QUEUE_DEPTH];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (count_q == DepthC);
  assign empty  = (count_q == '0);

  // command decode
  always_comb begin
    ctrl.ins = accept && (kind_i == spq_pkg::KindInsert) && !full;
    ctrl.pop = accept && (kind_i == spq_pkg::KindPop) && !empty;
  end

  // cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                lgt;
    logic [KEY_BITS-1:0] lkey, rkey;
    logic [TAG_BITS-1:0] ltag, rtag;

    assign valid_v[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign lgt  = 1'b0;
      assign lkey = '0;
      assign ltag = '0;
    end else begin : g_mid
      assign lgt  = gt_v[i-1];
      assign lkey = key_v[i-1];
      assign ltag = tag_v[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign rkey = '0;
      assign rtag = '0;
    end else begin : g_inner
      assign rkey = key_v[i+1];
      assign rtag = tag_v[i+1];
    end

    spq_cell #(
      .KEY_BITS(KEY_BITS),
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .valid_i    (valid_v[i]),
      .new_key_i  (due_key_i),
      .new_tag_i  (task_tag_i),
      .left_gt_i  (lgt),
      .left_key_i (lkey),
      .left_tag_i (ltag),
      .right_key_i(rkey),
      .right_tag_i(rtag),
      .gt_o       (gt_v[i]),
      .key_o      (key_v[i]),
      .tag_o      (tag_v[i])
    );
  end

  // occupancy and result formation
  always_comb begin
    count_d   = count_q;
    outcome_d = spq_pkg::OutInserted;
    ptag_d    = '0;
    pkey_d    = '0;
    if (kind_i == spq_pkg::KindInsert) begin
      if (full) begin
        outcome_d = spq_pkg::OutFull;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        outcome_d = spq_pkg::OutEmpty;
      end else begin
        outcome_d = spq_pkg::OutPopped;
        ptag_d    = tag_v[0];
        pkey_d    = key_v[0];
        count_d   = count_q - CntW'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      outcome_q <= outcome_d;
      ptag_q    <= ptag_d;
      pkey_q    <= pkey_d;
    end
  end

  assign done_o       = done_q;
  assign outcome_o    = outcome_q;
  assign popped_tag_o = ptag_q;
  assign popped_key_o = pkey_q;
  assign occupancy_o  = count_q;

endmodule

// ===== design/spq_checker.sv =====
// port-level checks for the stable sorted priority queue, bound to the top
module spq_checker #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QueueDepthDef,
  parameter int unsigned KEY_BITS    = spq_pkg::KeyBitsDef,
  parameter int unsigned TAG_BITS    = spq_pkg::TagBitsDef,
  localparam int unsigned CntW       = $clog2(QUEUE_DEPTH + 1)
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input logic                done_o,
  input logic [1:0]          outcome_o,
  input logic [TAG_BITS-1:0] popped_tag_o,
  input logic [KEY_BITS-1:0] popped_key_o,
  input logic [CntW-1:0]     occupancy_o
);

  // every transfer gives one result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> done_o)
    else $error("missing result after command transfer");

  // no result without a command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result without command");

  // a successful insert leaves at least one entry held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (outcome_o == spq_pkg::OutInserted) |-> occupancy_o != '0)
    else $error("insert reported with empty queue");

  // empty pop reports zeros on an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (outcome_o == spq_pkg::OutEmpty) |->
      (occupancy_o == '0) && (popped_key_o == '0) && (popped_tag_o == '0))
    else $error("empty pop inconsistent");

  // refused insert only when full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (outcome_o == spq_pkg::OutFull) |-> occupancy_o == CntW'(QUEUE_DEPTH))
    else $error("insert refused while not full");

endmodule

bind stable_sorted_priority_queue spq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH),
  .KEY_BITS   (KEY_BITS),
  .TAG_BITS   (TAG_BITS)
) u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .outcome_o   (outcome_o),
  .popped_tag_o(popped_tag_o),
  .popped_key_o(popped_key_o),
  .occupancy_o (occupancy_o)
);
